### rtl/max_flow_augmenting_paths_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the max-flow core checker
// Each macro expects clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef MAX_FLOW_AUGMENTING_PATHS_CORE_ASSERT_SVH
`define MAX_FLOW_AUGMENTING_PATHS_CORE_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent
`define MFAP_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent
`define MFAP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/mfap_pkg.sv
// ----------------------------------------------------------------------------
// mfap_pkg
// Shared types, codes and constants of the max-flow core.
// ----------------------------------------------------------------------------
`default_nettype none

package mfap_pkg;

    localparam int MAX_NODES_DEF = 64;
    localparam int CAP_BITS_DEF  = 16;

    localparam int OPC_W      = 2;
    localparam int NODE_FW    = 6;
    localparam int CAP_FW     = 16;
    localparam int IN_W       = 32;
    localparam int FLOW_W     = 22;
    localparam int OUT_W      = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    localparam logic [FLOW_W-1:0] FLOW_MAX = 22'h3FFFFF;

    localparam logic [CFG_DATA_W-1:0] NODE_COUNT_RST = 7'd64;
    localparam logic [NODE_FW-1:0]    SOURCE_RST     = 6'd0;
    localparam logic [NODE_FW-1:0]    SINK_RST       = 6'd1;

    typedef enum logic [OPC_W-1:0] {
        OP_CLEAR = 2'd0,
        OP_EDGE  = 2'd1,
        OP_RUN   = 2'd2
    } opcode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NODE_COUNT = 2'd0,
        CFG_SOURCE     = 2'd1,
        CFG_SINK       = 2'd2
    } cfg_index_t;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_CLEAR,
        CMD_COPY,
        CMD_INIT,
        CMD_DEQ,
        CMD_DEQ_WAIT,
        CMD_SCAN,
        CMD_WALK_P,
        CMD_WALK_U,
        CMD_WALK_F,
        CMD_WALK_B,
        CMD_FINISH
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t op;
    } cmd_t;

    typedef struct packed {
        logic sweep_done;
        logic queue_empty;
        logic target_found;
        logic scan_done;
        logic walk_phase;
        logic walk_last;
        logic run_skip;
        logic out_free;
    } sts_t;

endpackage

`default_nettype wire

### rtl/mfap_ram.sv
// ----------------------------------------------------------------------------
// mfap_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mfap_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### rtl/mfap_ctrl.sv
// ----------------------------------------------------------------------------
// mfap_ctrl
// Sequencer: steps the datapath through clear, copy, search and augment.
// ----------------------------------------------------------------------------
`default_nettype none

module mfap_ctrl (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    input  logic [mfap_pkg::OPC_W-1:0] opcode,
    output logic                       s_tready,
    input  mfap_pkg::sts_t             sts,
    output mfap_pkg::cmd_t             cmd
);

    import mfap_pkg::*;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_COPY,
        ST_INIT,
        ST_DEQ,
        ST_DEQ_WAIT,
        ST_SCAN,
        ST_WALK_P,
        ST_WALK_U,
        ST_WALK_F,
        ST_WALK_B,
        ST_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = CMD_NONE;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.op = CMD_CLEAR;
                if (sts.sweep_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.op = CMD_LOAD;
                    case (opcode_t'(opcode))
                        OP_CLEAR: state_next = ST_CLEAR;
                        OP_RUN:   state_next = sts.run_skip ? ST_FINISH : ST_COPY;
                        default:  state_next = ST_IDLE;
                    endcase
                end
            end
            ST_COPY:
            begin
                cmd.op = CMD_COPY;
                if (sts.sweep_done)
                begin
                    state_next = ST_INIT;
                end
            end
            ST_INIT:
            begin
                cmd.op     = CMD_INIT;
                state_next = ST_DEQ;
            end
            ST_DEQ:
            begin
                cmd.op = CMD_DEQ;
                if (!sts.queue_empty)
                begin
                    state_next = ST_DEQ_WAIT;
                end
                else if (sts.target_found)
                begin
                    state_next = ST_WALK_P;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_DEQ_WAIT:
            begin
                cmd.op     = CMD_DEQ_WAIT;
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                cmd.op = CMD_SCAN;
                if (sts.scan_done)
                begin
                    state_next = ST_DEQ;
                end
            end
            ST_WALK_P:
            begin
                cmd.op     = CMD_WALK_P;
                state_next = ST_WALK_U;
            end
            ST_WALK_U:
            begin
                cmd.op     = CMD_WALK_U;
                state_next = ST_WALK_F;
            end
            ST_WALK_F:
            begin
                cmd.op     = CMD_WALK_F;
                state_next = sts.walk_phase ? ST_WALK_B : ST_WALK_P;
            end
            ST_WALK_B:
            begin
                cmd.op     = CMD_WALK_B;
                state_next = sts.walk_last ? ST_INIT : ST_WALK_P;
            end
            ST_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.op     = CMD_FINISH;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

### rtl/mfap_datapath.sv
// ----------------------------------------------------------------------------
// mfap_datapath
// Capacity and residual matrices, search queue, parent table, visited marks,
// path walker, flow accumulator, configuration and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module mfap_datapath #(
    parameter int MAX_NODES = mfap_pkg::MAX_NODES_DEF,
    parameter int CAP_BITS  = mfap_pkg::CAP_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  mfap_pkg::cmd_t                  cmd,
    output mfap_pkg::sts_t                  sts,
    input  logic [mfap_pkg::IN_W-1:0]       s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [mfap_pkg::OUT_W-1:0]      m_tdata,
    input  logic                            cfg_we,
    input  logic [mfap_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mfap_pkg::CFG_DATA_W-1:0] cfg_data
);

    import mfap_pkg::*;

    localparam int NB    = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int NW    = NB + 1;
    localparam int AW    = 2 * NB;
    localparam int DEPTH = 1 << AW;
    localparam int RW    = CAP_BITS + 1;
    localparam int SW    = ((RW > FLOW_W) ? RW : FLOW_W) + 1;

    // configuration
    logic [CFG_DATA_W-1:0] node_count_reg;
    logic [NODE_FW-1:0]    src_cfg_reg;
    logic [NODE_FW-1:0]    snk_cfg_reg;

    // run state
    logic [NW-1:0]        n_reg;
    logic [NB-1:0]        s_reg;
    logic [NB-1:0]        t_reg;
    logic                 bad_reg;
    logic [AW:0]          sweep_cnt_reg;
    logic                 cp_valid_reg;
    logic [AW-1:0]        cp_addr_reg;
    logic [NW-1:0]        head_reg;
    logic [NW-1:0]        tail_reg;
    logic [NB-1:0]        u_reg;
    logic [NB-1:0]        v_reg;
    logic [NW-1:0]        iss_reg;
    logic [NB-1:0]        pv_reg;
    logic                 pv_valid_reg;
    logic [MAX_NODES-1:0] visited_reg;
    logic [RW-1:0]        bott_reg;
    logic                 phase_reg;
    logic [FLOW_W-1:0]    total_reg;
    logic                 out_valid_reg;
    logic [FLOW_W-1:0]    out_flow_reg;
    logic                 out_bad_reg;

    // memory ports
    logic                cap_we;
    logic [AW-1:0]       cap_waddr;
    logic [CAP_BITS-1:0] cap_wdata;
    logic [AW-1:0]       cap_raddr;
    logic [CAP_BITS-1:0] cap_rdata;
    logic                res_we;
    logic [AW-1:0]       res_waddr;
    logic [RW-1:0]       res_wdata;
    logic [AW-1:0]       res_raddr;
    logic [RW-1:0]       res_rdata;
    logic                par_we;
    logic [NB-1:0]       par_waddr;
    logic [NB-1:0]       par_wdata;
    logic [NB-1:0]       par_raddr;
    logic [NB-1:0]       par_rdata;
    logic                q_we;
    logic [NB-1:0]       q_waddr;
    logic [NB-1:0]       q_wdata;
    logic [NB-1:0]       q_raddr;
    logic [NB-1:0]       q_rdata;

    // input fields
    opcode_t             in_op;
    logic [NODE_FW-1:0]  in_from;
    logic [NODE_FW-1:0]  in_to;
    logic [CAP_FW-1:0]   in_cap;
    logic [CAP_BITS-1:0] cap_masked;
    logic                edge_ok;

    logic [31:0]   n_wide;
    logic [NW-1:0] n_eff;
    logic          scan_hit;
    logic          tail_room;
    logic [RW-1:0] new_bott;
    logic [SW-1:0] flow_sum;
    logic [FLOW_W-1:0] flow_sat;

    assign in_op      = opcode_t'(s_tdata[1:0]);
    assign in_from    = s_tdata[7:2];
    assign in_to      = s_tdata[13:8];
    assign in_cap     = s_tdata[29:14];
    assign cap_masked = CAP_BITS'(32'(in_cap));
    assign edge_ok    = (32'(in_from) < MAX_NODES) && (32'(in_to) < MAX_NODES);

    // clamp node count to 1 .. MAX_NODES
    always_comb
    begin
        n_wide = 32'(node_count_reg);
        if (n_wide == 32'd0)
        begin
            n_wide = 32'd1;
        end
        else if (n_wide > MAX_NODES)
        begin
            n_wide = MAX_NODES;
        end
        n_eff = NW'(n_wide);
    end

    assign tail_room = (32'(tail_reg) < MAX_NODES);
    assign scan_hit  = (cmd.op == CMD_SCAN) && pv_valid_reg && !visited_reg[pv_reg]
                       && (res_rdata != '0);
    assign new_bott  = (res_rdata < bott_reg) ? res_rdata : bott_reg;
    assign flow_sum  = SW'(total_reg) + SW'(new_bott);
    assign flow_sat  = (flow_sum > SW'(FLOW_MAX)) ? FLOW_MAX : flow_sum[FLOW_W-1:0];

    always_comb
    begin
        sts.sweep_done   = sweep_cnt_reg[AW] && !cp_valid_reg;
        sts.queue_empty  = (head_reg == tail_reg);
        sts.target_found = visited_reg[t_reg];
        sts.scan_done    = (iss_reg == n_reg) && !pv_valid_reg;
        sts.walk_phase   = phase_reg;
        sts.walk_last    = (u_reg == s_reg);
        sts.run_skip     = (src_cfg_reg == snk_cfg_reg)
                           || (32'(src_cfg_reg) >= 32'(n_eff))
                           || (32'(snk_cfg_reg) >= 32'(n_eff));
        sts.out_free     = !out_valid_reg || m_tready;
    end

    // memory port steering
    always_comb
    begin
        cap_we    = 1'b0;
        cap_waddr = sweep_cnt_reg[AW-1:0];
        cap_wdata = '0;
        cap_raddr = sweep_cnt_reg[AW-1:0];

        res_we    = cp_valid_reg;
        res_waddr = cp_addr_reg;
        res_wdata = {1'b0, cap_rdata};
        res_raddr = {u_reg, iss_reg[NB-1:0]};

        par_we    = scan_hit;
        par_waddr = pv_reg;
        par_wdata = u_reg;
        par_raddr = v_reg;

        q_we      = scan_hit && tail_room;
        q_waddr   = tail_reg[NB-1:0];
        q_wdata   = pv_reg;
        q_raddr   = head_reg[NB-1:0];

        case (cmd.op)
            CMD_LOAD:
            begin
                if (in_op == OP_EDGE && edge_ok)
                begin
                    cap_we    = 1'b1;
                    cap_waddr = {NB'(in_from), NB'(in_to)};
                    cap_wdata = cap_masked;
                end
            end
            CMD_CLEAR:
            begin
                cap_we = !sweep_cnt_reg[AW];
            end
            CMD_INIT:
            begin
                par_we    = 1'b1;
                par_waddr = s_reg;
                par_wdata = s_reg;
                q_we      = 1'b1;
                q_waddr   = '0;
                q_wdata   = s_reg;
            end
            CMD_WALK_U:
            begin
                res_raddr = {par_rdata, v_reg};
            end
            CMD_WALK_F:
            begin
                res_raddr = {v_reg, u_reg};
                if (phase_reg)
                begin
                    res_we    = 1'b1;
                    res_waddr = {u_reg, v_reg};
                    res_wdata = res_rdata - bott_reg;
                end
            end
            CMD_WALK_B:
            begin
                res_we    = 1'b1;
                res_waddr = {v_reg, u_reg};
                res_wdata = res_rdata + bott_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= NODE_COUNT_RST;
            src_cfg_reg    <= SOURCE_RST;
            snk_cfg_reg    <= SINK_RST;
            n_reg          <= '0;
            s_reg          <= '0;
            t_reg          <= '0;
            bad_reg        <= 1'b0;
            sweep_cnt_reg  <= '0;
            cp_valid_reg   <= 1'b0;
            cp_addr_reg    <= '0;
            head_reg       <= '0;
            tail_reg       <= '0;
            u_reg          <= '0;
            v_reg          <= '0;
            iss_reg        <= '0;
            pv_reg         <= '0;
            pv_valid_reg   <= 1'b0;
            visited_reg    <= '0;
            bott_reg       <= '0;
            phase_reg      <= 1'b0;
            total_reg      <= '0;
            out_valid_reg  <= 1'b0;
            out_flow_reg   <= '0;
            out_bad_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_NODE_COUNT: node_count_reg <= cfg_data;
                    CFG_SOURCE:     src_cfg_reg    <= cfg_data[NODE_FW-1:0];
                    CFG_SINK:       snk_cfg_reg    <= cfg_data[NODE_FW-1:0];
                    default:        ;
                endcase
            end

            // drop the result once taken, unless a new one is loaded this cycle
            if (m_tready && (cmd.op != CMD_FINISH))
            begin
                out_valid_reg <= 1'b0;
            end

            case (cmd.op)
                CMD_LOAD:
                begin
                    sweep_cnt_reg <= '0;
                    cp_valid_reg  <= 1'b0;
                    if (in_op == OP_RUN)
                    begin
                        n_reg     <= n_eff;
                        s_reg     <= NB'(src_cfg_reg);
                        t_reg     <= NB'(snk_cfg_reg);
                        bad_reg   <= (src_cfg_reg == snk_cfg_reg);
                        total_reg <= '0;
                    end
                end
                CMD_CLEAR:
                begin
                    if (!sweep_cnt_reg[AW])
                    begin
                        sweep_cnt_reg <= sweep_cnt_reg + 1'b1;
                    end
                end
                CMD_COPY:
                begin
                    // read one capacity a cycle, write it to the residual next cycle
                    if (!sweep_cnt_reg[AW])
                    begin
                        sweep_cnt_reg <= sweep_cnt_reg + 1'b1;
                        cp_valid_reg  <= 1'b1;
                        cp_addr_reg   <= sweep_cnt_reg[AW-1:0];
                    end
                    else
                    begin
                        cp_valid_reg <= 1'b0;
                    end
                end
                CMD_INIT:
                begin
                    visited_reg <= MAX_NODES'(1) << s_reg;
                    head_reg    <= '0;
                    tail_reg    <= NW'(1);
                end
                CMD_DEQ:
                begin
                    if (head_reg == tail_reg)
                    begin
                        v_reg     <= t_reg;
                        bott_reg  <= '1;
                        phase_reg <= 1'b0;
                    end
                    else
                    begin
                        head_reg <= head_reg + 1'b1;
                    end
                end
                CMD_DEQ_WAIT:
                begin
                    u_reg        <= q_rdata;
                    iss_reg      <= '0;
                    pv_valid_reg <= 1'b0;
                end
                CMD_SCAN:
                begin
                    if (iss_reg < n_reg)
                    begin
                        iss_reg      <= iss_reg + 1'b1;
                        pv_reg       <= iss_reg[NB-1:0];
                        pv_valid_reg <= 1'b1;
                    end
                    else
                    begin
                        pv_valid_reg <= 1'b0;
                    end
                    if (scan_hit)
                    begin
                        visited_reg[pv_reg] <= 1'b1;
                        if (tail_room)
                        begin
                            tail_reg <= tail_reg + 1'b1;
                        end
                    end
                end
                CMD_WALK_U:
                begin
                    u_reg <= par_rdata;
                end
                CMD_WALK_F:
                begin
                    if (!phase_reg)
                    begin
                        bott_reg <= new_bott;
                        if (u_reg == s_reg)
                        begin
                            phase_reg <= 1'b1;
                            v_reg     <= t_reg;
                            total_reg <= flow_sat;
                        end
                        else
                        begin
                            v_reg <= u_reg;
                        end
                    end
                end
                CMD_WALK_B:
                begin
                    v_reg <= u_reg;
                end
                CMD_FINISH:
                begin
                    out_valid_reg <= 1'b1;
                    out_flow_reg  <= total_reg;
                    out_bad_reg   <= bad_reg;
                end
                default:
                begin
                end
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_bad_reg, out_flow_reg};

    mfap_ram #(.WIDTH(CAP_BITS), .DEPTH(DEPTH)) u_cap_ram (
        .clk   (clk),
        .we    (cap_we),
        .waddr (cap_waddr),
        .wdata (cap_wdata),
        .raddr (cap_raddr),
        .rdata (cap_rdata)
    );

    mfap_ram #(.WIDTH(RW), .DEPTH(DEPTH)) u_res_ram (
        .clk   (clk),
        .we    (res_we),
        .waddr (res_waddr),
        .wdata (res_wdata),
        .raddr (res_raddr),
        .rdata (res_rdata)
    );

    mfap_ram #(.WIDTH(NB), .DEPTH(1 << NB)) u_par_ram (
        .clk   (clk),
        .we    (par_we),
        .waddr (par_waddr),
        .wdata (par_wdata),
        .raddr (par_raddr),
        .rdata (par_rdata)
    );

    mfap_ram #(.WIDTH(NB), .DEPTH(1 << NB)) u_queue_ram (
        .clk   (clk),
        .we    (q_we),
        .waddr (q_waddr),
        .wdata (q_wdata),
        .raddr (q_raddr),
        .rdata (q_rdata)
    );

endmodule

`default_nettype wire

### rtl/max_flow_augmenting_paths_core.sv
// ----------------------------------------------------------------------------
// max_flow_augmenting_paths_core
// Maximum flow by shortest augmenting paths over a directed capacity matrix.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries command transfers: clear the matrix, write one edge capacity,
//   or run a maximum-flow computation. Only a run produces a result transfer
//   on m_*. cfg_* sets node count, source and sink; write it only while idle.
//   Edge write: the core stays idle, so the next command may follow immediately.
//   Clear: one sweep of the capacity memory, one entry a cycle
//   (MAX_NODES rounded up to a power of two, squared: 4096 entries by default).
//   Run: a copy sweep of the same length into the residual memory, then per
//   search a scan of the n residual entries of each dequeued node (residual
//   memory read port), plus bottleneck and update walks along the path edges.
//   A run with equal or out-of-range terminals skips the search and goes straight to its result.
//   Reset: the capacity memory is swept to zero first; s_tready stays low
//   until that sweep is done. Config registers return to 64 / 0 / 1.
//   A stalled result waits in the output register; s_tready stays low until
//   the pending run's result can be loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module max_flow_augmenting_paths_core #(
    parameter int MAX_NODES = mfap_pkg::MAX_NODES_DEF,
    parameter int CAP_BITS  = mfap_pkg::CAP_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // opcode[1:0], from_node[7:2], to_node[13:8], capacity[29:14], zero pad
    input  logic [mfap_pkg::IN_W-1:0]       s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // max_flow[21:0], bad_terminals[22], zero pad
    output logic [mfap_pkg::OUT_W-1:0]      m_tdata,
    input  logic                            cfg_we,
    input  logic [mfap_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mfap_pkg::CFG_DATA_W-1:0] cfg_data
);

    import mfap_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // sequencer: decides which datapath step runs each cycle
    mfap_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .opcode   (s_tdata[OPC_W-1:0]),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // matrices, search structures and result register
    mfap_datapath #(
        .MAX_NODES (MAX_NODES),
        .CAP_BITS  (CAP_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule

`default_nettype wire

### rtl/mfap_checker.sv
// ----------------------------------------------------------------------------
// mfap_checker
// Port-level checks of the max-flow core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "max_flow_augmenting_paths_core_assert.svh"

module mfap_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic [mfap_pkg::IN_W-1:0]       s_tdata,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [mfap_pkg::OUT_W-1:0]      m_tdata,
    input logic                            cfg_we,
    input logic [mfap_pkg::CFG_IDX_W-1:0]  cfg_index,
    input logic [mfap_pkg::CFG_DATA_W-1:0] cfg_data
);

    import mfap_pkg::*;

    logic run_in;
    logic edge_in;
    logic cfg_seen;

    assign run_in   = s_tvalid && s_tready && (s_tdata[OPC_W-1:0] == OP_RUN);
    assign edge_in  = s_tvalid && s_tready && (s_tdata[OPC_W-1:0] == OP_EDGE);
    assign cfg_seen = cfg_we && (cfg_index != '0 || cfg_data != '0 || 1'b1);

    `MFAP_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result dropped or changed while stalled")
    `MFAP_ASSERT_NEXT(a_run_busy, run_in, !s_tready, "command taken during a run")
    `MFAP_ASSERT_NEXT(a_edge_quick, edge_in && !cfg_seen, s_tready, "edge write did not return to idle")
    `MFAP_ASSERT_SAME(a_bad_zero, m_tvalid && m_tdata[FLOW_W], m_tdata[FLOW_W-1:0] == '0, "flow not zero with equal terminals")
    `MFAP_ASSERT_SAME(a_result_busy, $rose(m_tvalid), $past(!s_tready), "result raised while idle")

endmodule

bind max_flow_augmenting_paths_core mfap_checker u_mfap_checker (.*);

`default_nettype wire

### tb/max_flow_augmenting_paths_core_test.sv
// ----------------------------------------------------------------------------
// max_flow_augmenting_paths_core_test
// Self-checking bench for the max-flow core: a directed table of commands,
// then random phases of config, edge loads and runs. Each run is checked
// field by field against a flow predictor kept inside the bench.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module max_flow_augmenting_paths_core_test;

    import mfap_pkg::*;

    localparam logic [OPC_W-1:0] OP_UNUSED = 2'd3;   // ignored by the core
    localparam int               GRID      = 64;     // matrix row pitch

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_W-1:0]       s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_W-1:0]      m_tdata;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    max_flow_augmenting_paths_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------------
    // Flow predictor: its own copy of the capacity matrix and registers
    // ------------------------------------------------------------------------
    logic [CAP_FW-1:0]     cap_mem [GRID*GRID];
    int                    res_mem [GRID*GRID];
    bit                    seen    [GRID];
    int                    parent  [GRID];
    int                    bfs_q   [GRID];
    logic [CFG_DATA_W-1:0] nodes_reg;
    logic [NODE_FW-1:0]    src_reg;
    logic [NODE_FW-1:0]    dst_reg;

    typedef struct packed {
        logic              bad;
        logic [FLOW_W-1:0] flow;
    } flow_res_t;

    flow_res_t flow_q[$];   // results still owed by the core

    // Breadth-first search in index order; true when the sink was reached
    function automatic bit find_path(int n, int s, int t);
        int head;
        int tail;
        int u;
        head = 0;
        tail = 0;
        for (int i = 0; i < GRID; i++) seen[i] = 0;
        seen[s]   = 1;
        parent[s] = s;
        bfs_q[tail++] = s;
        while (head < tail)
        begin
            u = bfs_q[head++];
            for (int v = 0; v < n; v++)
            begin
                if (!seen[v] && res_mem[u*GRID+v] > 0)
                begin
                    seen[v]   = 1;
                    parent[v] = u;
                    if (tail < GRID) bfs_q[tail++] = v;
                end
            end
        end
        return seen[t];
    endfunction

    function automatic logic [FLOW_W-1:0] solve_flow(int n, int s, int t);
        longint total;
        int     neck;
        int     u;
        int     v;
        total = 0;
        for (int i = 0; i < GRID*GRID; i++) res_mem[i] = cap_mem[i];
        while (find_path(n, s, t))
        begin
            neck = 32'h7FFF_FFFF;
            for (v = t; v != s; v = u)
            begin
                u = parent[v];
                if (res_mem[u*GRID+v] < neck) neck = res_mem[u*GRID+v];
            end
            for (v = t; v != s; v = u)
            begin
                u = parent[v];
                res_mem[u*GRID+v] -= neck;
                res_mem[v*GRID+u] += neck;
            end
            total += neck;
            if (total > FLOW_MAX) total = FLOW_MAX;
        end
        return total[FLOW_W-1:0];
    endfunction

    // Apply one accepted command; true when it owes a result
    function automatic bit apply_command(input logic [IN_W-1:0] d, output flow_res_t r);
        logic [OPC_W-1:0]   op;
        logic [NODE_FW-1:0] from_n;
        logic [NODE_FW-1:0] to_n;
        int                 n;
        op     = d[1:0];
        from_n = d[7:2];
        to_n   = d[13:8];
        r      = '0;
        if (op == OP_CLEAR)
        begin
            for (int i = 0; i < GRID*GRID; i++) cap_mem[i] = '0;
            return 0;
        end
        if (op == OP_EDGE)
        begin
            cap_mem[from_n*GRID+to_n] = d[29:14];
            return 0;
        end
        if (op != OP_RUN) return 0;
        n = nodes_reg;
        if (n == 0)  n = 1;
        if (n > GRID) n = GRID;
        if (src_reg == dst_reg)
            r.bad = 1'b1;
        else if (src_reg < n && dst_reg < n)
            r.flow = solve_flow(n, src_reg, dst_reg);
        return 1;
    endfunction

    function automatic logic [IN_W-1:0] pack_cmd(logic [OPC_W-1:0] op, int f, int t, int c);
        logic [NODE_FW-1:0] fv;
        logic [NODE_FW-1:0] tv;
        logic [CAP_FW-1:0]  cv;
        fv = NODE_FW'(f);
        tv = NODE_FW'(t);
        cv = CAP_FW'(c);
        return {2'b00, cv, tv, fv, op};
    endfunction

    // ------------------------------------------------------------------------
    // Command sender: bursts of random length with random gaps
    // ------------------------------------------------------------------------
    int burst_left;
    int items_sent;
    int runs_sent;

    task automatic send_cmd(input logic [IN_W-1:0] d, input bit typed, input flow_res_t want);
        flow_res_t r;
        bit        owed;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 2) != 0)
            begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        // the transfer happened at this edge
        owed = apply_command(d, r);
        items_sent++;
        if (owed)
        begin
            runs_sent++;
            flow_q.insert(flow_q.size(), typed ? want : r);
        end
    endtask

    // Hold until every result is in, then let the core settle
    task automatic wait_idle();
        s_tvalid   <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (flow_q.size() != 0 || !s_tready) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input int v);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(v);
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_NODE_COUNT: nodes_reg = CFG_DATA_W'(v);
            CFG_SOURCE:     src_reg   = NODE_FW'(v);
            default:        dst_reg   = NODE_FW'(v);
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Result receiver: its own stall pattern, checks each transfer
    // ------------------------------------------------------------------------
    int        stall_left;
    bit        calm;
    int        mismatches;
    int        results_seen;
    flow_res_t oldest;

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen++;
            if (flow_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result flow=%0d bad=%0b", m_tdata[21:0], m_tdata[22]);
            end
            else
            begin
                oldest = flow_q.pop_front();
                if (m_tdata[21:0] !== oldest.flow || m_tdata[22] !== oldest.bad)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch: expected flow=%0d bad=%0b, got flow=%0d bad=%0b",
                                 oldest.flow, oldest.bad, m_tdata[21:0], m_tdata[22]);
                end
            end
        end
        // alternate calm stretches with stretches of random stalls
        if ($urandom_range(0, 199) == 0) calm = !calm;
        if (stall_left > 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else if (!calm && $urandom_range(0, 3) == 0)
        begin
            stall_left = $urandom_range(0, 11);
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    // ------------------------------------------------------------------------
    // Directed table
    // ------------------------------------------------------------------------
    typedef enum logic {ROW_REG, ROW_CMD} row_kind_t;

    typedef struct {
        row_kind_t       kind;
        cfg_index_t      idx;
        logic [IN_W-1:0] d;
        bit              typed;
        flow_res_t       want;
    } row_t;

    row_t rows[$];

    function automatic void add_cmd(logic [OPC_W-1:0] op, int f, int t, int c,
                                    bit typed = 0, int fl = 0, bit bad = 0);
        row_t r;
        r.kind      = ROW_CMD;
        r.idx       = CFG_NODE_COUNT;
        r.d         = pack_cmd(op, f, t, c);
        r.typed     = typed;
        r.want.flow = FLOW_W'(fl);
        r.want.bad  = bad;
        rows.insert(rows.size(), r);
    endfunction

    function automatic void add_reg(cfg_index_t idx, int v);
        row_t r;
        r.kind  = ROW_REG;
        r.idx   = idx;
        r.d     = IN_W'(v);
        r.typed = 0;
        r.want  = '0;
        rows.insert(rows.size(), r);
    endfunction

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int n_eff;
        int phase_len;
        int a;
        int b;
        int c;

        clk        = 1'b0;
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        m_tready   = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = CFG_NODE_COUNT;
        cfg_data   = '0;
        burst_left = 0;
        stall_left = 0;
        calm       = 1'b0;
        nodes_reg  = NODE_COUNT_RST;
        src_reg    = SOURCE_RST;
        dst_reg    = SINK_RST;
        for (int i = 0; i < GRID*GRID; i++) cap_mem[i] = '0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        // hold off until the reset sweep of the matrix is done
        @(posedge clk);
        while (!s_tready) @(posedge clk);

        // empty matrix after reset, single full edge, overwrite to zero
        add_cmd(OP_RUN, 0, 0, 0, 1, 0, 0);
        add_cmd(OP_EDGE, 0, 1, 16'hFFFF);
        add_cmd(OP_RUN, 0, 0, 0, 1, 65535, 0);
        add_cmd(OP_EDGE, 0, 1, 0);
        add_cmd(OP_RUN, 0, 0, 0, 1, 0, 0);
        // a path through the top node indices, plus an unused opcode
        add_cmd(OP_EDGE, 0, 63, 16'hFFFF);
        add_cmd(OP_EDGE, 63, 62, 16'h8000);
        add_cmd(OP_EDGE, 62, 1, 16'h7FFF);
        add_cmd(OP_EDGE, 63, 1, 1);
        add_cmd(OP_UNUSED, 63, 63, 16'hFFFF);
        add_cmd(OP_RUN, 0, 0, 0);
        // clear wipes it all
        add_cmd(OP_CLEAR, 0, 0, 0);
        add_cmd(OP_RUN, 0, 0, 0, 1, 0, 0);
        // source equals sink
        add_reg(CFG_SINK, 0);
        add_cmd(OP_EDGE, 0, 1, 5);
        add_cmd(OP_RUN, 0, 0, 0, 1, 0, 1);
        // sink outside the node count
        add_reg(CFG_NODE_COUNT, 2);
        add_reg(CFG_SINK, 5);
        add_cmd(OP_RUN, 0, 0, 0, 1, 0, 0);
        // node count zero acts as one: sink 1 falls outside
        add_reg(CFG_NODE_COUNT, 0);
        add_reg(CFG_SINK, 1);
        add_cmd(OP_RUN, 0, 0, 0, 1, 0, 0);
        // node count above the maximum acts as the maximum
        add_reg(CFG_NODE_COUNT, 127);
        add_reg(CFG_SOURCE, 63);
        add_reg(CFG_SINK, 1);
        add_cmd(OP_EDGE, 63, 62, 300);
        add_cmd(OP_EDGE, 62, 1, 200);
        add_cmd(OP_RUN, 0, 0, 0);

        foreach (rows[i])
        begin
            if (rows[i].kind == ROW_REG)
            begin
                wait_idle();
                write_reg(rows[i].idx, rows[i].d);
            end
            else
                send_cmd(rows[i].d, rows[i].typed, rows[i].want);
        end

        // random phases: new settings, mostly small graphs, then a run
        while (items_sent < 1700)
        begin
            wait_idle();
            case ($urandom_range(0, 9))
                0:       write_reg(CFG_NODE_COUNT, $urandom_range(0, 127));
                1:       write_reg(CFG_NODE_COUNT, 64);
                2, 3:    write_reg(CFG_NODE_COUNT, $urandom_range(9, 20));
                default: write_reg(CFG_NODE_COUNT, $urandom_range(2, 8));
            endcase
            n_eff = nodes_reg == 0 ? 1 : (nodes_reg > GRID ? GRID : nodes_reg);
            a = $urandom_range(0, n_eff - 1);
            b = $urandom_range(0, n_eff - 1);
            if (n_eff > 1)
                while (b == a) b = $urandom_range(0, n_eff - 1);
            if ($urandom_range(0, 19) == 0) b = a;
            if ($urandom_range(0, 19) == 0) b = $urandom_range(0, 63);
            write_reg(CFG_SOURCE, a);
            write_reg(CFG_SINK, b);
            if ($urandom_range(0, 4) == 0) send_cmd(pack_cmd(OP_CLEAR, 0, 0, 0), 0, '0);
            phase_len = $urandom_range(5, 20);
            for (int k = 0; k < phase_len; k++)
            begin
                c = $urandom_range(0, 3) == 0 ? $urandom_range(0, 65535) : $urandom_range(0, 40);
                if ($urandom_range(0, 19) == 0)
                    send_cmd(pack_cmd(OP_UNUSED, $urandom_range(0, 63), $urandom_range(0, 63),
                                      $urandom_range(0, 65535)), 0, '0);
                else if ($urandom_range(0, 6) == 0)
                    send_cmd(pack_cmd(OP_EDGE, $urandom_range(0, 63), $urandom_range(0, 63), c),
                             0, '0);
                else if ($urandom_range(0, 3) == 0)
                    // chain through a random node from source to sink
                    send_cmd(pack_cmd(OP_EDGE, k[0] ? $urandom_range(0, n_eff - 1) : a,
                                      k[0] ? b : $urandom_range(0, n_eff - 1), c), 0, '0);
                else
                    send_cmd(pack_cmd(OP_EDGE, $urandom_range(0, n_eff - 1),
                                      $urandom_range(0, n_eff - 1), c), 0, '0);
                if ($urandom_range(0, 24) == 0) send_cmd(pack_cmd(OP_RUN, 0, 0, 0), 0, '0);
            end
            send_cmd(pack_cmd(OP_RUN, $urandom_range(0, 63), $urandom_range(0, 63),
                              $urandom_range(0, 65535)), 0, '0);
        end

        s_tvalid <= 1'b0;
        @(posedge clk);
        while (flow_q.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);

        $display("Covered %0d commands, %0d flow runs, %0d results checked, %0d mismatches.",
                 items_sent, runs_sent, results_seen, mismatches);
        if (mismatches == 0 && flow_q.size() == 0)
            $display("** max_flow_augmenting_paths_core: PASSED **");
        else
            $display("** max_flow_augmenting_paths_core: FAILED **");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial
    begin
        #60ms;
        $display("timeout with %0d results outstanding", flow_q.size());
        $display("** max_flow_augmenting_paths_core: FAILED **");
        $finish;
    end

endmodule
